[design/brk_pkg.sv]
// Shared types and constants for the braking-curve motion profile.
// No dependencies; imported by braking_curve_motion_profile.
package brk_pkg;

  localparam int FractionBits = 8;

  localparam int SpeedW = 17;
  localparam int PosW   = 32;
  localparam int TolW   = 16;
  localparam int DtW    = 16;
  localparam int CfgW   = 17;
  localparam int InW    = 120;
  localparam int OutW   = 120;

  localparam logic [SpeedW-1:0] MaxSpeedReset = SpeedW'(450 << FractionBits);
  localparam logic [SpeedW-1:0] AccelReset    = SpeedW'(180 << FractionBits);
  localparam logic [TolW-1:0]   TolReset      = TolW'(((1 << FractionBits) + 5) / 10);

  // register indexes on the write port
  typedef enum logic [1:0] {
    REG_MAX_SPEED = 2'd0,
    REG_ACCEL     = 2'd1,
    REG_TOLERANCE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_AXIS_X = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_SET    = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BRK_MUL,
    ST_BRK_SQRT,
    ST_RAMP_MUL,
    ST_MOVE_MUL,
    ST_MOVE_APPLY,
    ST_CHK0,
    ST_AX_MUL,
    ST_AX_DIV,
    ST_AX_APPLY,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_DIST_SQRT,
    ST_DIST_SAVE,
    ST_OUT
  } state_t;

  // iteration counts of the shared units
  localparam logic [5:0] MulSteps  = 6'd34;
  localparam logic [5:0] SqrtSteps = 6'd34;
  localparam logic [5:0] DivSteps  = 6'd50;

  // signed difference of two positions, one bit wider
  function automatic logic signed [PosW:0] pos_diff(input logic signed [PosW-1:0] t,
                                                    input logic signed [PosW-1:0] p);
    pos_diff = {t[PosW-1], t} - {p[PosW-1], p};
  endfunction

  function automatic logic [PosW:0] mag33(input logic signed [PosW:0] v);
    mag33 = v[PosW] ? (PosW+1)'(-v) : v;
  endfunction

  // move speed toward desired by at most step
  function automatic logic [SpeedW-1:0] ramp(input logic [SpeedW-1:0] desired,
                                             input logic [SpeedW-1:0] cur,
                                             input logic [SpeedW-1:0] step);
    logic [SpeedW-1:0] res;
    if (desired > cur) begin
      res = ((desired - cur) > step) ? cur + step : desired;
    end else begin
      res = ((cur - desired) > step) ? cur - step : desired;
    end
    ramp = res;
  endfunction

endpackage

[design/braking_curve_motion_profile.sv]
// Braking-curve motion profile: one tick of a trapezoidal speed profile per input beat.
// Depends on brk_pkg. One shared serial multiplier, square root and divider under a sequencer.
//
// Each input beat is one motion tick; the block takes no new beat until the result beat has
// been taken. A tick runs one multiply-shift pass per product, one square-root pass per root
// and one restoring divide per axis, each with a load step: in mode 0 a braking product and
// root, a ramp product and a move product; in mode 1 three squares and a root before the move
// and again after it, an optional braking product and root, and three axis products and
// divides unless the target is reached that tick; in mode 2 or an unused mode none of these.
// A stalled result beat adds its stall. Register writes take effect at once and should only
// be made while the block is idle.
module braking_curve_motion_profile (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_index,
  input  logic [brk_pkg::CfgW-1:0]     wr_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // target_x[31:0], target_y[63:32], target_z[95:64], stop_at_target[96],
  // step_time[112:97], zero fill above
  input  logic [brk_pkg::InW-1:0]      s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // arrived[0], pos_x[32:1], pos_y[64:33], pos_z[96:65], speed_out[113:97], zero fill above
  output logic [brk_pkg::OutW-1:0]     m_axis_tdata
);
  import brk_pkg::*;

  state_t state, state_next;
  logic [5:0] cnt;

  logic [SpeedW-1:0] max_speed, acceleration, speed, desired, move;
  logic [TolW-1:0]   tolerance;
  logic signed [PosW-1:0] px, py, pz, tx, ty, tz;
  logic [1:0]  mode;
  logic        stop, second, arrived;
  logic [DtW-1:0] dt;
  logic [1:0]  axis;
  logic [33:0] distance;

  // shared units
  logic [67:0] mcand, prod, sq_src;
  logic [33:0] mplier, root;
  logic [36:0] rem;
  logic [49:0] num;
  logic [34:0] drem;

  logic signed [PosW:0] dxv, dyv, dzv, dsel;
  logic [PosW:0] adx, ady, adz, asel;
  logic signed [PosW-1:0] psel;
  logic [SpeedW-1:0] prod_hi, ramped, brk_des;
  logic [36:0] sq_next, sq_trial;
  logic [34:0] div_next;
  logic [PosW:0] mv0;
  logic [PosW:0] q;
  logic signed [PosW:0] stepped;

  assign dxv = pos_diff(tx, px);
  assign dyv = pos_diff(ty, py);
  assign dzv = pos_diff(tz, pz);
  assign adx = mag33(dxv);
  assign ady = mag33(dyv);
  assign adz = mag33(dzv);

  always_comb begin
    case (axis)
      2'd0:    begin dsel = dxv; psel = px; end
      2'd1:    begin dsel = dyv; psel = py; end
      default: begin dsel = dzv; psel = pz; end
    endcase
  end
  assign asel = mag33(dsel);

  assign prod_hi  = prod[32:16];
  assign ramped   = ramp(desired, speed, prod_hi);
  assign brk_des  = (root < {17'd0, max_speed}) ? root[SpeedW-1:0] : max_speed;
  assign sq_next  = {rem[34:0], sq_src[67:66]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign div_next = {drem[33:0], num[49]};
  assign mv0      = ({16'd0, prod_hi} > adx) ? adx : {16'd0, prod_hi};
  assign q        = num[PosW:0];
  assign stepped  = dsel[PosW] ? $signed({psel[PosW-1], psel}) - $signed(q)
                               : $signed({psel[PosW-1], psel}) + $signed(q);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            MODE_AXIS_X: state_next = ST_BRK_MUL;
            MODE_POINT:  state_next = ST_SQ_X;
            default:     state_next = ST_OUT;
          endcase
        end
      end
      ST_BRK_MUL:   if (cnt == MulSteps)  state_next = ST_BRK_SQRT;
      ST_BRK_SQRT:  if (cnt == SqrtSteps) state_next = ST_RAMP_MUL;
      ST_RAMP_MUL:  if (cnt == MulSteps)  state_next = ST_MOVE_MUL;
      ST_MOVE_MUL:  if (cnt == MulSteps)  state_next = ST_MOVE_APPLY;
      ST_MOVE_APPLY: begin
        if (mode == MODE_AXIS_X)               state_next = ST_CHK0;
        else if (distance <= {17'd0, prod_hi}) state_next = ST_SQ_X;
        else                                   state_next = ST_AX_MUL;
      end
      ST_CHK0:      state_next = ST_OUT;
      ST_AX_MUL:    if (cnt == MulSteps) state_next = ST_AX_DIV;
      ST_AX_DIV:    if (cnt == DivSteps) state_next = ST_AX_APPLY;
      ST_AX_APPLY:  state_next = (axis == 2'd2) ? ST_SQ_X : ST_AX_MUL;
      ST_SQ_X:      if (cnt == MulSteps)  state_next = ST_SQ_Y;
      ST_SQ_Y:      if (cnt == MulSteps)  state_next = ST_SQ_Z;
      ST_SQ_Z:      if (cnt == MulSteps)  state_next = ST_DIST_SQRT;
      ST_DIST_SQRT: if (cnt == SqrtSteps) state_next = ST_DIST_SAVE;
      ST_DIST_SAVE: begin
        if (second)    state_next = ST_OUT;
        else if (stop) state_next = ST_BRK_MUL;
        else           state_next = ST_RAMP_MUL;
      end
      ST_OUT:       if (m_axis_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    m_axis_tdata  = {6'd0, speed, pz, py, px, arrived};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      max_speed    <= MaxSpeedReset;
      acceleration <= AccelReset;
      tolerance    <= TolReset;
      speed        <= '0;
      px           <= '0;
      py           <= '0;
      pz           <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 6'd0 : cnt + 6'd1;

      if (wr_en) begin
        case (wr_index)
          REG_MAX_SPEED: max_speed    <= wr_data;
          REG_ACCEL:     acceleration <= wr_data;
          REG_TOLERANCE: tolerance    <= wr_data[TolW-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode    <= s_axis_tuser;
            tx      <= s_axis_tdata[31:0];
            ty      <= s_axis_tdata[63:32];
            tz      <= s_axis_tdata[95:64];
            stop    <= s_axis_tdata[96];
            dt      <= s_axis_tdata[112:97];
            second  <= 1'b0;
            axis    <= 2'd0;
            arrived <= 1'b0;
            if (s_axis_tuser == MODE_SET) begin
              px      <= s_axis_tdata[31:0];
              py      <= s_axis_tdata[63:32];
              pz      <= s_axis_tdata[95:64];
              speed   <= '0;
              arrived <= 1'b1;
            end
          end
        end
        ST_BRK_MUL: begin
          if (cnt == 6'd0) begin
            mcand  <= {51'd0, acceleration};
            mplier <= (mode == MODE_AXIS_X) ? {1'b0, adx} : distance;
            prod   <= '0;
          end
        end
        ST_BRK_SQRT: begin
          if (cnt == 6'd0) begin
            sq_src <= {prod[66:0], 1'b0};
            rem    <= '0;
            root   <= '0;
          end
        end
        ST_RAMP_MUL: begin
          if (cnt == 6'd0) begin
            desired <= (mode == MODE_AXIS_X || stop) ? brk_des : max_speed;
            mcand   <= {51'd0, acceleration};
            mplier  <= {18'd0, dt};
            prod    <= '0;
          end
        end
        ST_MOVE_MUL: begin
          if (cnt == 6'd0) begin
            speed  <= ramped;
            mcand  <= {51'd0, ramped};
            mplier <= {18'd0, dt};
            prod   <= '0;
          end
        end
        ST_MOVE_APPLY: begin
          move <= prod_hi;
          if (mode == MODE_AXIS_X) begin
            px <= dxv[PosW] ? PosW'($signed({px[PosW-1], px}) - $signed(mv0))
                            : PosW'($signed({px[PosW-1], px}) + $signed(mv0));
          end else if (distance <= {17'd0, prod_hi}) begin
            px     <= tx;
            py     <= ty;
            pz     <= tz;
            second <= 1'b1;
          end
        end
        ST_CHK0: begin
          if (adx < {17'd0, tolerance}) begin
            speed   <= '0;
            arrived <= 1'b1;
          end
        end
        ST_AX_MUL: begin
          if (cnt == 6'd0) begin
            mcand  <= {35'd0, asel};
            mplier <= {17'd0, move};
            prod   <= '0;
          end
        end
        ST_AX_DIV: begin
          if (cnt == 6'd0) begin
            num  <= prod[49:0];
            drem <= '0;
          end
        end
        ST_AX_APPLY: begin
          case (axis)
            2'd0:    px <= stepped[PosW-1:0];
            2'd1:    py <= stepped[PosW-1:0];
            default: pz <= stepped[PosW-1:0];
          endcase
          axis <= axis + 2'd1;
          if (axis == 2'd2) second <= 1'b1;
        end
        ST_SQ_X: begin
          if (cnt == 6'd0) begin
            mcand  <= {35'd0, adx};
            mplier <= {1'b0, adx};
            prod   <= '0;
          end
        end
        ST_SQ_Y: begin
          // hold the running sum of squares
          if (cnt == 6'd0) begin
            mcand  <= {35'd0, ady};
            mplier <= {1'b0, ady};
          end
        end
        ST_SQ_Z: begin
          if (cnt == 6'd0) begin
            mcand  <= {35'd0, adz};
            mplier <= {1'b0, adz};
          end
        end
        ST_DIST_SQRT: begin
          if (cnt == 6'd0) begin
            sq_src <= prod;
            rem    <= '0;
            root   <= '0;
          end
        end
        ST_DIST_SAVE: begin
          if (!second) begin
            distance <= root;
          end else if (root <= {18'd0, tolerance}) begin
            px      <= tx;
            py      <= ty;
            pz      <= tz;
            arrived <= 1'b1;
            if (stop) speed <= '0;
          end
        end
        default: ;
      endcase

      // shared unit iterations
      if (cnt != 6'd0) begin
        case (state)
          ST_BRK_MUL, ST_RAMP_MUL, ST_MOVE_MUL, ST_AX_MUL, ST_SQ_X, ST_SQ_Y, ST_SQ_Z: begin
            if (mplier[0]) prod <= prod + mcand;
            mcand  <= {mcand[66:0], 1'b0};
            mplier <= {1'b0, mplier[33:1]};
          end
          ST_BRK_SQRT, ST_DIST_SQRT: begin
            sq_src <= {sq_src[65:0], 2'b00};
            if (sq_next >= sq_trial) begin
              rem  <= sq_next - sq_trial;
              root <= {root[32:0], 1'b1};
            end else begin
              rem  <= sq_next;
              root <= {root[32:0], 1'b0};
            end
          end
          ST_AX_DIV: begin
            if (div_next >= {1'b0, distance}) begin
              drem <= div_next - {1'b0, distance};
              num  <= {num[48:0], 1'b1};
            end else begin
              drem <= div_next;
              num  <= {num[48:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[design/brk_checker.sv]
// Port-level checks for braking_curve_motion_profile, bound to the top level.
// Depends on brk_pkg for the result bus width.
module brk_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [brk_pkg::OutW-1:0] m_axis_tdata
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // one tick in flight: never ready while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready held after accepting a tick");

  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after result taken");
endmodule

bind braking_curve_motion_profile brk_checker u_brk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
